[rtl/core/ofht_pkg.sv]
// ----------------------------------------------------------------------------
// ofht_pkg
// Shared types, codes and the key hash for the owner/descriptor file table.
// ----------------------------------------------------------------------------
package ofht_pkg;

	localparam int TABLE_LOG  = 5;
	localparam int TABLE_SIZE = 1 << TABLE_LOG;
	localparam int ADDR_W     = TABLE_LOG;
	localparam int PROBE_W    = (TABLE_LOG > 2) ? $clog2(TABLE_LOG) : 1;
	localparam int SLOT_W     = 5;
	localparam int KEY_W      = 32;
	localparam int VALUE_W    = 32;

	localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_OK        = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_FULL      = 2'd2,
		RES_ALREADY   = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_USED = 2'd1,
		ST_TOMB = 2'd2,
		ST_RSVD = 2'd3
	} slot_state_t;

	// One table entry as it sits in the slot memory.
	typedef struct packed {
		slot_state_t         state;
		logic [KEY_W-1:0]    owner;
		logic [KEY_W-1:0]    fd;
		logic [VALUE_W-1:0]  value;
	} entry_t;

	// Start slot of a key. Only the low bits of the sum are kept, so synthesis
	// trims the adders down to ADDR_W bits.
	function automatic logic [ADDR_W-1:0] start_slot(input logic [KEY_W-1:0] a,
		input logic [KEY_W-1:0] b);
		logic [31:0] h;
		h = a ^ (b + HASH_GOLDEN + (a << 6) + (a >> 2));
		return h[ADDR_W-1:0];
	endfunction

endpackage

[rtl/core/owner_fd_hash_table.sv]
// Probing: the first read of the slot memory is issued at the accepting edge, and
// each later probe reads the next slot of the quadratic chain, up to TABLE_LOG probes.
// Throughput: one item at a time; the next word is taken in the cycle after the
// result is registered. A result that waits in the output register stalls the
// probing of the following item.
// Reset: arst_n clears all control state and the per-slot valid flags at once,
// so every slot reads as free right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// owner_fd_hash_table
// Open-addressing file table keyed by owner thread and descriptor, with
// quadratic probing over one synchronous slot memory.
// ----------------------------------------------------------------------------
module owner_fd_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // owner [31:0], fd [63:32], entry_value [95:64]
	input  logic [1:0]  s_tuser,   // command [1:0]
	// Response channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // slot [4:0], stored_value [36:5], zero [39:37]
	output logic [1:0]  m_tuser    // status [1:0]
);

	typedef enum logic {
		S_IDLE,
		S_PROBE
	} state_t;

	// Outcome of evaluating one probed slot.
	typedef struct packed {
		logic                        done;
		logic                        advance;
		logic                        wr_en;
		ofht_pkg::entry_t            wr_entry;
		ofht_pkg::res_t              status;
		logic [ofht_pkg::SLOT_W-1:0] slot;
		logic [ofht_pkg::VALUE_W-1:0] value;
	} probe_dec_t;

	localparam logic [ofht_pkg::PROBE_W-1:0] LAST_PROBE =
		ofht_pkg::PROBE_W'(ofht_pkg::TABLE_LOG - 1);

	state_t                          state_q;
	ofht_pkg::cmd_t                  cmd_q;
	logic [ofht_pkg::KEY_W-1:0]      owner_q;
	logic [ofht_pkg::KEY_W-1:0]      fd_q;
	logic [ofht_pkg::VALUE_W-1:0]    value_q;
	logic [ofht_pkg::ADDR_W-1:0]     start_q;
	logic [ofht_pkg::ADDR_W-1:0]     addr_q;
	logic [ofht_pkg::ADDR_W-1:0]     sq_q;
	logic [ofht_pkg::PROBE_W-1:0]    probe_q;
	logic [ofht_pkg::TABLE_SIZE-1:0] valid_q;

	logic                            m_tvalid_q;
	ofht_pkg::res_t                  res_status_q;
	logic [ofht_pkg::SLOT_W-1:0]     res_slot_q;
	logic [ofht_pkg::VALUE_W-1:0]    res_value_q;

	// Slot memory with a registered read port.
	ofht_pkg::entry_t                mem [ofht_pkg::TABLE_SIZE];
	ofht_pkg::entry_t                rd_s1;

	logic                            accept;
	logic                            out_free;
	logic [ofht_pkg::ADDR_W-1:0]     in_start;
	logic [ofht_pkg::ADDR_W-1:0]     step;
	logic [ofht_pkg::ADDR_W-1:0]     next_addr;
	logic                            rd_en;
	logic [ofht_pkg::ADDR_W-1:0]     rd_addr;
	ofht_pkg::slot_state_t           cur_state;
	logic                            key_match;
	logic                            last_probe;
	probe_dec_t                      dec;

	// The block takes a new request only between items; a result still waiting
	// in the output register does not hold off the next request.
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign in_start = ofht_pkg::start_slot(s_tdata[31:0], s_tdata[63:32]);

	// Quadratic offsets built incrementally: (i+1)^2 = i^2 + 2i + 1.
	assign step      = ofht_pkg::ADDR_W'({probe_q, 1'b1});
	assign next_addr = start_q + sq_q + step;

	// A slot that was never written reads as free through its valid flag.
	assign cur_state  = valid_q[addr_q] ? rd_s1.state : ofht_pkg::ST_FREE;
	assign key_match  = (cur_state == ofht_pkg::ST_USED) && (rd_s1.owner == owner_q)
		&& (rd_s1.fd == fd_q);
	assign last_probe = (probe_q == LAST_PROBE);

	always_comb begin
		dec          = '0;
		dec.status   = ofht_pkg::RES_NOT_FOUND;
		dec.wr_entry = rd_s1;
		if (state_q == S_PROBE && out_free) begin
			case (cmd_q)
				ofht_pkg::CMD_INSERT: begin
					if (cur_state != ofht_pkg::ST_USED) begin
						// First free or tombstone slot takes the new entry.
						dec.done           = 1'b1;
						dec.wr_en          = 1'b1;
						dec.wr_entry.state = ofht_pkg::ST_USED;
						dec.wr_entry.owner = owner_q;
						dec.wr_entry.fd    = fd_q;
						dec.wr_entry.value = value_q;
						dec.status         = ofht_pkg::RES_OK;
						dec.slot           = ofht_pkg::SLOT_W'(addr_q);
					end else if (key_match) begin
						dec.done   = 1'b1;
						dec.status = ofht_pkg::RES_ALREADY;
					end else if (last_probe) begin
						dec.done   = 1'b1;
						dec.status = ofht_pkg::RES_FULL;
					end else begin
						dec.advance = 1'b1;
					end
				end
				ofht_pkg::CMD_LOOKUP, ofht_pkg::CMD_DELETE: begin
					if (cur_state == ofht_pkg::ST_FREE) begin
						dec.done = 1'b1;
					end else if (key_match) begin
						dec.done   = 1'b1;
						dec.status = ofht_pkg::RES_OK;
						dec.slot   = ofht_pkg::SLOT_W'(addr_q);
						if (cmd_q == ofht_pkg::CMD_LOOKUP) begin
							dec.value = rd_s1.value;
						end else begin
							dec.wr_en          = 1'b1;
							dec.wr_entry.state = ofht_pkg::ST_TOMB;
						end
					end else if (last_probe) begin
						dec.done = 1'b1;
					end else begin
						dec.advance = 1'b1;
					end
				end
				default: begin
					// The unused command changes nothing and answers not found.
					dec.done = 1'b1;
				end
			endcase
		end
	end

	assign rd_en   = accept || dec.advance;
	assign rd_addr = accept ? in_start : next_addr;

	// A write is always the last action of an item, and the next read is issued
	// no earlier than the following cycle, so read and write never collide.
	always_ff @(posedge clk) begin
		if (dec.wr_en) begin
			mem[addr_q] <= dec.wr_entry;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= ofht_pkg::CMD_LOOKUP;
			owner_q      <= '0;
			fd_q         <= '0;
			value_q      <= '0;
			start_q      <= '0;
			addr_q       <= '0;
			sq_q         <= '0;
			probe_q      <= '0;
			valid_q      <= '0;
			m_tvalid_q   <= 1'b0;
			res_status_q <= ofht_pkg::RES_OK;
			res_slot_q   <= '0;
			res_value_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !dec.done) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= ofht_pkg::cmd_t'(s_tuser);
						owner_q <= s_tdata[31:0];
						fd_q    <= s_tdata[63:32];
						value_q <= s_tdata[95:64];
						start_q <= in_start;
						addr_q  <= in_start;
						sq_q    <= '0;
						probe_q <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (dec.advance) begin
						probe_q <= probe_q + 1'b1;
						sq_q    <= sq_q + step;
						addr_q  <= next_addr;
					end
					if (dec.wr_en) begin
						valid_q[addr_q] <= 1'b1;
					end
					if (dec.done) begin
						m_tvalid_q   <= 1'b1;
						res_status_q <= dec.status;
						res_slot_q   <= dec.slot;
						res_value_q  <= dec.value;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_value_q, res_slot_q};
	assign m_tuser  = res_status_q;

	// A result word only appears at the end of a probe sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_PROBE))
		else $error("result raised outside a probe sequence");

	// The probe counter never runs past the last quadratic offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (probe_q <= LAST_PROBE))
		else $error("probe index out of range");

	// Only insert and delete modify the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		dec.wr_en |-> (cmd_q == ofht_pkg::CMD_INSERT || cmd_q == ofht_pkg::CMD_DELETE))
		else $error("table write from a lookup or unused command");

	// A write ends the item, so the block is idle in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		dec.wr_en |=> (state_q == S_IDLE) && m_tvalid_q)
		else $error("write not followed by a result");

	// Any status other than ok carries slot and value of zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_status_q != ofht_pkg::RES_OK) |->
		(res_slot_q == '0 && res_value_q == '0))
		else $error("failed request reports a slot or value");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the owner/descriptor file table. A directed table
// covers the hash-collision corner cases, then random traffic runs over
// clustered key sets; responses are checked against a row or behavioral table.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	// Generous bound: about 1700 words, each allowed a long sender gap, the
	// full probe chain and a long receiver stall, taken several times over.
	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 250;
	localparam int POOL_SIZE   = 32;
	localparam int N_DIRECTED  = 24;

	// One response word as the table answers it.
	typedef struct {
		ofht_pkg::res_t              status;
		logic [ofht_pkg::SLOT_W-1:0] slot;
		logic [31:0]                 stored;
	} response_t;

	// One row of the directed table. When known is set, the response fields
	// in the row are the expectation; otherwise the behavioral table decides.
	typedef struct {
		ofht_pkg::cmd_t              cmd;
		logic [31:0]                 owner;
		logic [31:0]                 fd;
		logic [31:0]                 value;
		bit                          known;
		ofht_pkg::res_t              status;
		logic [ofht_pkg::SLOT_W-1:0] slot;
		logic [31:0]                 stored;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // owner [31:0], fd [63:32], entry_value [95:64]
	logic [1:0]  s_tuser;   // command [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // slot [4:0], stored_value [36:5], zero [39:37]
	logic [1:0]  m_tuser;   // status [1:0]

	// Behavioral copy of the slot memory.
	ofht_pkg::slot_state_t table_state [ofht_pkg::TABLE_SIZE];
	logic [31:0]           table_owner [ofht_pkg::TABLE_SIZE];
	logic [31:0]           table_fd    [ofht_pkg::TABLE_SIZE];
	logic [31:0]           table_value [ofht_pkg::TABLE_SIZE];

	response_t   pending_responses [$];
	int unsigned errors;
	int unsigned cycles;
	bit          tx_steady;
	bit          rx_steady;
	int unsigned stall_left;

	logic [31:0] pool_owner [POOL_SIZE];
	logic [31:0] pool_fd    [POOL_SIZE];

	// Keys with owner 0 and descriptors that are multiples of 32 all hash to
	// the same start slot, so the first six inserts walk the whole probe chain
	// and the sixth finds the table full for that key.
	request_row_t directed_rows [N_DIRECTED] = '{
		'{ofht_pkg::CMD_LOOKUP, 32'h0, 32'h0, 32'h0,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_DELETE, 32'hFFFFFFFF, 32'h80000000, 32'h0,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_UNUSED, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd0, 32'hFFFFFFFF,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd32, 32'h1,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd64, 32'h2,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd96, 32'h3,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd128, 32'h4,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd160, 32'h5,
			1'b1, ofht_pkg::RES_FULL, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd0, 32'h6,
			1'b1, ofht_pkg::RES_ALREADY, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'h0, 32'd128, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_DELETE, 32'h0, 32'd0, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'h0, 32'd0, 32'h0,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'h0, 32'd64, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'h0, 32'd64, 32'hAAAA5555,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'h0, 32'd64, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_UNUSED, 32'h0, 32'd64, 32'h0,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_DELETE, 32'h0, 32'd64, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_DELETE, 32'h0, 32'd64, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_DELETE, 32'h0, 32'd64, 32'h0,
			1'b1, ofht_pkg::RES_NOT_FOUND, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'h80000000, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 32'h80000000, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0},
		'{ofht_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0,
			1'b0, ofht_pkg::RES_OK, 5'd0, 32'h0}
	};

	owner_fd_hash_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Home slot of a key: the mixed 32-bit hash cut down to the table index.
	function automatic int unsigned home_slot(logic [31:0] owner, logic [31:0] fd);
		logic [31:0] mixed;
		mixed = owner ^ (fd + ofht_pkg::HASH_GOLDEN + (owner << 6) + (owner >> 2));
		return mixed & (ofht_pkg::TABLE_SIZE - 1);
	endfunction

	// Applies one request to the behavioral table and returns its response.
	// Lookup and delete step over tombstones and stop at a free slot; insert
	// claims the first slot that is not in use unless it meets its own key.
	function automatic response_t apply_table_request(ofht_pkg::cmd_t cmd,
		logic [31:0] owner, logic [31:0] fd, logic [31:0] value);
		response_t   r;
		int unsigned start;
		int unsigned s;
		bit          done;
		r.status = ofht_pkg::RES_NOT_FOUND;
		r.slot   = '0;
		r.stored = '0;
		start    = home_slot(owner, fd);
		done     = 1'b0;
		case (cmd)
			ofht_pkg::CMD_LOOKUP, ofht_pkg::CMD_DELETE: begin
				for (int i = 0; i < ofht_pkg::TABLE_LOG && !done; i++) begin
					s = (start + i * i) & (ofht_pkg::TABLE_SIZE - 1);
					if (table_state[s] == ofht_pkg::ST_FREE) begin
						done = 1'b1;
					end else if (table_state[s] == ofht_pkg::ST_USED &&
						table_owner[s] == owner && table_fd[s] == fd) begin
						done     = 1'b1;
						r.status = ofht_pkg::RES_OK;
						r.slot   = s[ofht_pkg::SLOT_W-1:0];
						if (cmd == ofht_pkg::CMD_LOOKUP) begin
							r.stored = table_value[s];
						end else begin
							table_state[s] = ofht_pkg::ST_TOMB;
						end
					end
				end
			end
			ofht_pkg::CMD_INSERT: begin
				r.status = ofht_pkg::RES_FULL;
				for (int i = 0; i < ofht_pkg::TABLE_LOG && !done; i++) begin
					s = (start + i * i) & (ofht_pkg::TABLE_SIZE - 1);
					if (table_state[s] != ofht_pkg::ST_USED) begin
						done           = 1'b1;
						table_state[s] = ofht_pkg::ST_USED;
						table_owner[s] = owner;
						table_fd[s]    = fd;
						table_value[s] = value;
						r.status       = ofht_pkg::RES_OK;
						r.slot         = s[ofht_pkg::SLOT_W-1:0];
					end else if (table_owner[s] == owner && table_fd[s] == fd) begin
						done     = 1'b1;
						r.status = ofht_pkg::RES_ALREADY;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: response %s is %h, should be %h", $time, field, got, want);
		errors++;
	endtask

	// Presents one request word and waits for its handshake. The expected
	// response is queued at the edge that accepts the word, so the behavioral
	// table advances in exactly the order the block takes requests.
	task automatic send_word(ofht_pkg::cmd_t cmd, logic [31:0] owner, logic [31:0] fd,
		logic [31:0] value, bit known, response_t known_resp);
		int unsigned gap;
		response_t   r;
		gap = tx_steady ? 0 : idle_gap();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, fd, owner};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		r = apply_table_request(cmd, owner, fd, value);
		pending_responses.push_back(known ? known_resp : r);
	endtask

	// Drops valid and holds off until every queued response has come back.
	task automatic wait_for_responses();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
	endtask

	// Deletes every key still in use, so each phase starts with a table of
	// free slots and tombstones. A key inserted twice gets two deletes.
	task automatic clear_table();
		logic [31:0] owners [$];
		logic [31:0] fds [$];
		response_t   none;
		none = '{ofht_pkg::RES_OK, '0, '0};
		for (int s = 0; s < ofht_pkg::TABLE_SIZE; s++) begin
			if (table_state[s] == ofht_pkg::ST_USED) begin
				owners.push_back(table_owner[s]);
				fds.push_back(table_fd[s]);
			end
		end
		foreach (owners[k]) begin
			send_word(ofht_pkg::CMD_DELETE, owners[k], fds[k], $urandom, 1'b0, none);
		end
		wait_for_responses();
	endtask

	// Builds four clusters of eight keys. Within a cluster the owner is fixed
	// and the descriptors differ by multiples of 32, so all of them share a
	// home slot and fight over the same probe chain.
	task automatic build_key_pool(int phase);
		logic [31:0] owner;
		logic [31:0] base;
		for (int c = 0; c < POOL_SIZE / 8; c++) begin
			if (c == 0 && phase % 2 == 0) owner = 32'h0;
			else if (c == 1 && phase % 2 == 1) owner = 32'hFFFFFFFF;
			else owner = $urandom;
			base = $urandom;
			for (int k = 0; k < 8; k++) begin
				pool_owner[c*8+k] = owner;
				pool_fd[c*8+k]    = base + 32'(k * 32);
			end
		end
	endtask

	// Mostly requests on pooled keys, so lookups and deletes hit and inserts
	// collide; one word in eight is a fully random key and command.
	task automatic send_random_word();
		ofht_pkg::cmd_t cmd;
		logic [31:0]    owner;
		logic [31:0]    fd;
		int unsigned    idx;
		int unsigned    pick;
		response_t      none;
		none = '{ofht_pkg::RES_OK, '0, '0};
		if ($urandom_range(0, 7) == 0) begin
			cmd   = ofht_pkg::cmd_t'($urandom_range(0, 3));
			owner = $urandom;
			fd    = $urandom;
		end else begin
			idx   = $urandom_range(0, POOL_SIZE - 1);
			owner = pool_owner[idx];
			fd    = pool_fd[idx];
			pick  = $urandom_range(0, 99);
			if (pick < 40) cmd = ofht_pkg::CMD_INSERT;
			else if (pick < 70) cmd = ofht_pkg::CMD_LOOKUP;
			else if (pick < 97) cmd = ofht_pkg::CMD_DELETE;
			else cmd = ofht_pkg::CMD_UNUSED;
		end
		send_word(cmd, owner, fd, $urandom, 1'b0, none);
	endtask

	// Response side: ready with random stalls, except in a steady phase.
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				m_tready   <= 1'b0;
				stall_left = stall_left - 1;
			end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
				m_tready   <= 1'b0;
				stall_left = idle_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every accepted response word is compared with the oldest expectation.
	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t ns: response word with nothing outstanding", $time);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				if (m_tuser != want.status) begin
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				end
				if (m_tdata[4:0] != want.slot) begin
					report_mismatch("slot", 32'(m_tdata[4:0]), 32'(want.slot));
				end
				if (m_tdata[36:5] != want.stored) begin
					report_mismatch("stored_value", m_tdata[36:5], want.stored);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("owner_fd_hash_table: mismatch");
			$finish;
		end
	end

	initial begin
		response_t known_resp;
		errors    = 0;
		cycles    = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		for (int s = 0; s < ofht_pkg::TABLE_SIZE; s++) begin
			table_state[s] = ofht_pkg::ST_FREE;
			table_owner[s] = '0;
			table_fd[s]    = '0;
			table_value[s] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[n]) begin
			known_resp = '{directed_rows[n].status, directed_rows[n].slot,
				directed_rows[n].stored};
			send_word(directed_rows[n].cmd, directed_rows[n].owner, directed_rows[n].fd,
				directed_rows[n].value, directed_rows[n].known, known_resp);
		end
		clear_table();

		// One phase with a sender that never idles and one with a receiver
		// that never stalls; each phase ends with the table emptied and the
		// sender held until every response is back.
		for (int phase = 0; phase < PHASES; phase++) begin
			tx_steady = (phase == 2);
			rx_steady = (phase == 3);
			build_key_pool(phase);
			repeat (PHASE_WORDS) send_random_word();
			clear_table();
		end

		repeat (ofht_pkg::TABLE_LOG + 8) @(posedge clk);
		if (errors == 0) begin
			$display("owner_fd_hash_table: match");
		end else begin
			$display("owner_fd_hash_table: mismatch");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/ofht_pkg.sv
rtl/core/owner_fd_hash_table.sv
verif/tb.sv
